// ----- sv/mpq_pkg.sv -----
package mpq_pkg;

	localparam int PID_W = 4;
	localparam int CNT_W = 5;

	typedef logic [PID_W-1:0] pid_t;

	typedef enum logic [1:0] {
		OP_ENQ   = 2'd0,
		OP_DEQ   = 2'd1,
		OP_SCHED = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_NULL   = 2'd2,
		STS_QUEUED = 2'd3
	} status_t;

	// one queue descriptor: head, tail and occupancy of a FIFO
	typedef struct packed {
		pid_t             head;
		pid_t             tail;
		logic [CNT_W-1:0] cnt;
	} desc_t;

endpackage

// ----- sv/mpq_if.sv -----
interface mpq_req_if;
	import mpq_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic       queue_set;
	pid_t       process_id;
	logic [1:0] priority_req;
	logic       has_process;

	modport source (output valid, opcode, queue_set, process_id, priority_req, has_process,
		input ready);
	modport sink (input valid, opcode, queue_set, process_id, priority_req, has_process,
		output ready);
endinterface

interface mpq_rsp_if;
	import mpq_pkg::*;
	logic       valid;
	logic       ready;
	logic       found;
	pid_t       out_process_id;
	logic [1:0] status;
	pid_t       current_process;

	modport source (output valid, found, out_process_id, status, current_process,
		input ready);
	modport sink (input valid, found, out_process_id, status, current_process,
		output ready);
endinterface

interface mpq_cfg_if;
	import mpq_pkg::*;
	logic valid;
	logic ready;
	pid_t null_process_id;

	modport source (output valid, null_process_id, input ready);
	modport sink (input valid, null_process_id, output ready);
endinterface

// ----- sv/multilevel_priority_ready_queue.sv -----
// Flow: enqueue, direct or null schedule, rejected and empty requests read their descriptor
// and then register their result; a dequeue or schedule that pops a queue goes through the
// descriptor RAM read, then the link RAM read at the queue head, then write-back and result.
// One request at a time; a result waits while the previous result has not been taken.
// Reset: all queues empty, queued flags cleared, current process and null process id 0;
// the link RAM is not cleared and needs no clearing pass.
module multilevel_priority_ready_queue #(
	parameter int PRIORITY_LEVELS = 4,
	parameter int MAX_PROCESSES   = 16
) (
	input logic clk,
	input logic arst_n,
	mpq_req_if.sink   req,
	mpq_rsp_if.source rsp,
	mpq_cfg_if.sink   cfg
);
	import mpq_pkg::*;

	localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
	localparam int SLOTS  = 2 * (1 << LVL_W);
	localparam int SLOT_W = LVL_W + 1;
	localparam int PROC_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DESC = 3'b010,
		ST_LINK = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [1:0][PRIORITY_LEVELS-1:0] ne_q;
	logic [MAX_PROCESSES-1:0]        inq_q;
	pid_t                            running_q;
	pid_t                            null_q;

	opcode_t           op_q;
	pid_t              pid_q;
	logic              direct_q;
	logic              pop_q;
	logic              enq_ok_q;
	logic [SLOT_W-1:0] slot_q;

	logic    rsp_valid_q;
	logic    found_q;
	pid_t    out_pid_q;
	status_t status_q;

	// request decode
	opcode_t                    c_op;
	logic                       c_set;
	logic [PRIORITY_LEVELS-1:0] c_ne;
	logic                       c_have;
	logic [LVL_W-1:0]           c_best;
	logic [LVL_W-1:0]           c_prio;
	logic                       c_is_pop;
	logic                       c_enq_ok;
	logic [SLOT_W-1:0]          c_slot;
	logic                       acc;

	// memories
	logic              desc_we;
	desc_t             desc_wdata;
	desc_t             desc_rd;
	logic [$bits(desc_t)-1:0] desc_rd_raw;
	logic              link_we;
	logic              link_re;
	pid_t              link_rd;
	logic              slot_ne;

	logic    ofree;
	logic    fin;
	logic    found_d;
	pid_t    out_pid_d;
	status_t status_d;
	pid_t    running_d;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign c_op     = opcode_t'(req.opcode);
	assign c_set    = (c_op == OP_SCHED) ? 1'b0 : req.queue_set;
	assign c_ne     = ne_q[c_set];
	assign c_have   = |c_ne;
	assign c_is_pop = (c_op == OP_DEQ) || ((c_op == OP_SCHED) && !req.has_process);
	assign c_enq_ok = (c_op == OP_ENQ) && (32'(req.process_id) < MAX_PROCESSES)
		&& !inq_q[PROC_W'(req.process_id)];

	always_comb begin
		c_best = '0;
		for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
			if (c_ne[i]) begin
				c_best = LVL_W'(i);
			end
		end
	end

	// saturate to the lowest level
	assign c_prio = (32'(req.priority_req) >= PRIORITY_LEVELS) ?
		LVL_W'(PRIORITY_LEVELS - 1) : LVL_W'(req.priority_req);
	assign c_slot = c_is_pop ? {c_set, c_best} : {req.queue_set, c_prio};

	assign ofree   = !rsp_valid_q || rsp.ready;
	assign fin     = ofree && (((state_q == ST_DESC) && !pop_q) || (state_q == ST_LINK));
	assign desc_rd = desc_t'(desc_rd_raw);

	// an empty queue's descriptor may be stale or never written: trust the flag
	assign slot_ne = ne_q[slot_q[LVL_W]][slot_q[LVL_W-1:0]];

	mpq_ram #(
		.DATA_W ($bits(desc_t)),
		.DEPTH  (SLOTS)
	) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (slot_q),
		.wdata (desc_wdata),
		.re    (acc),
		.raddr (c_slot),
		.rdata (desc_rd_raw)
	);

	assign link_re = (state_q == ST_DESC) && pop_q;
	assign link_we = fin && (state_q == ST_DESC) && enq_ok_q && slot_ne;

	mpq_ram #(
		.DATA_W (PID_W),
		.DEPTH  (MAX_PROCESSES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (PROC_W'(desc_rd.tail)),
		.wdata (pid_q),
		.re    (link_re),
		.raddr (PROC_W'(desc_rd.head)),
		.rdata (link_rd)
	);

	// descriptor write-back
	always_comb begin
		desc_we    = 1'b0;
		desc_wdata = desc_rd;
		if (fin && (state_q == ST_DESC) && enq_ok_q) begin
			desc_we         = 1'b1;
			desc_wdata.head = slot_ne ? desc_rd.head : pid_q;
			desc_wdata.tail = pid_q;
			desc_wdata.cnt  = slot_ne ? desc_rd.cnt + CNT_W'(1) : CNT_W'(1);
		end else if (fin && (state_q == ST_LINK)) begin
			desc_we         = 1'b1;
			desc_wdata.head = (desc_rd.cnt != CNT_W'(1)) ? link_rd : desc_rd.head;
			desc_wdata.cnt  = desc_rd.cnt - CNT_W'(1);
		end
	end

	// result of the request in hand
	always_comb begin
		found_d   = 1'b0;
		out_pid_d = '0;
		status_d  = STS_OK;
		running_d = running_q;
		case (op_q)
			OP_ENQ: begin
				status_d = enq_ok_q ? STS_OK : STS_QUEUED;
			end
			OP_DEQ: begin
				if (pop_q) begin
					found_d   = 1'b1;
					out_pid_d = desc_rd.head;
				end else begin
					status_d = STS_EMPTY;
				end
			end
			OP_SCHED: begin
				found_d = 1'b1;
				if (direct_q) begin
					running_d = pid_q;
				end else if (pop_q) begin
					running_d = desc_rd.head;
				end else begin
					running_d = null_q;
					status_d  = STS_NULL;
				end
				out_pid_d = running_d;
			end
			default: begin
				found_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = ST_DESC;
				end
			end
			ST_DESC: begin
				if (pop_q) begin
					state_d = ST_LINK;
				end else if (fin) begin
					state_d = ST_IDLE;
				end
			end
			ST_LINK: begin
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ne_q        <= '0;
			inq_q       <= '0;
			running_q   <= '0;
			null_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				null_q <= cfg.null_process_id;
			end
			if (fin && (state_q == ST_DESC) && enq_ok_q) begin
				ne_q[slot_q[LVL_W]][slot_q[LVL_W-1:0]] <= 1'b1;
				inq_q[PROC_W'(pid_q)]                 <= 1'b1;
			end
			if (fin && (state_q == ST_LINK)) begin
				ne_q[slot_q[LVL_W]][slot_q[LVL_W-1:0]] <= (desc_rd.cnt != CNT_W'(1));
				inq_q[PROC_W'(desc_rd.head)]          <= 1'b0;
			end
			if (fin) begin
				running_q   <= running_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= c_op;
			pid_q    <= req.process_id;
			direct_q <= req.has_process;
			pop_q    <= c_is_pop && c_have;
			enq_ok_q <= c_enq_ok;
			slot_q   <= c_slot;
		end
		if (fin) begin
			found_q   <= found_d;
			out_pid_q <= out_pid_d;
			status_q  <= status_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.found           = found_q;
	assign rsp.out_process_id  = out_pid_q;
	assign rsp.status          = status_q;
	assign rsp.current_process = running_q;

endmodule

// ----- sv/mpq_ram.sv -----
module mpq_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
